/* src/c6502s_pkg.sv */
package c6502s_pkg;

  // sequencer phases
  localparam logic [3:0] PH_RST_LO = 4'd0;
  localparam logic [3:0] PH_RST_HI = 4'd1;
  localparam logic [3:0] PH_OPCODE = 4'd2;
  localparam logic [3:0] PH_OPER1  = 4'd3;
  localparam logic [3:0] PH_OPER2  = 4'd4;
  localparam logic [3:0] PH_PTR_LO = 4'd5;
  localparam logic [3:0] PH_PTR_HI = 4'd6;
  localparam logic [3:0] PH_READ   = 4'd7;
  localparam logic [3:0] PH_WRITE  = 4'd8;
  localparam logic [3:0] PH_PUSH1  = 4'd9;
  localparam logic [3:0] PH_PUSH2  = 4'd10;
  localparam logic [3:0] PH_PUSH3  = 4'd11;
  localparam logic [3:0] PH_POP1   = 4'd12;
  localparam logic [3:0] PH_POP2   = 4'd13;
  localparam logic [3:0] PH_POP3   = 4'd14;

  typedef enum logic [4:0] {
    M_IMP, M_IMM, M_ZP, M_ZPX, M_ZPY, M_ABS, M_ABSX, M_ABSY, M_INDX, M_INDY,
    M_REL, M_JMP, M_JMPI, M_JSR, M_RTS, M_RTI, M_BRK, M_PHA, M_PHP, M_PLA, M_PLP
  } mode_e;

  typedef enum logic [4:0] {
    K_NONE, K_LDA, K_LDX, K_LDY, K_ADC, K_SBC, K_AND, K_ORA, K_EOR, K_CMP,
    K_CPX, K_CPY, K_BIT, K_STA, K_STX, K_STY, K_INC, K_DEC
  } kind_e;

  typedef struct packed {
    mode_e      mode;
    kind_e      kind;
    logic [2:0] ncyc;
  } op_info_t;

  localparam logic [7:0] F_CARRY = 8'h01;
  localparam logic [7:0] F_ZERO  = 8'h02;
  localparam logic [7:0] F_IRQD  = 8'h04;
  localparam logic [7:0] F_DEC   = 8'h08;
  localparam logic [7:0] F_BRKB  = 8'h10;
  localparam logic [7:0] F_OVFL  = 8'h40;
  localparam logic [7:0] F_NEG   = 8'h80;

  localparam logic [15:0] VEC_RST_LO = 16'hFFFC;
  localparam logic [15:0] VEC_RST_HI = 16'hFFFD;
  localparam logic [15:0] VEC_BRK    = 16'hFFFE;

  // core architectural state
  typedef struct packed {
    logic [15:0] pc;
    logic [7:0]  a;
    logic [7:0]  x;
    logic [7:0]  y;
    logic [7:0]  sp;
    logic [7:0]  p;
    logic [7:0]  op;
    logic [3:0]  ph;
    logic [15:0] al;
    logic [31:0] cyc;
    logic [7:0]  hold;
    logic [2:0]  last;
  } core_t;

  function automatic op_info_t decode(input logic [7:0] c);
    op_info_t d;
    d = '{M_IMP, K_NONE, 3'd2};
    unique case (c)
      8'hA9: d = '{M_IMM, K_LDA, 3'd2};  8'hA5: d = '{M_ZP, K_LDA, 3'd3};
      8'hB5: d = '{M_ZPX, K_LDA, 3'd4};  8'hAD: d = '{M_ABS, K_LDA, 3'd4};
      8'hBD: d = '{M_ABSX, K_LDA, 3'd4}; 8'hB9: d = '{M_ABSY, K_LDA, 3'd4};
      8'hA1: d = '{M_INDX, K_LDA, 3'd6}; 8'hB1: d = '{M_INDY, K_LDA, 3'd5};
      8'hA2: d = '{M_IMM, K_LDX, 3'd2};  8'hA6: d = '{M_ZP, K_LDX, 3'd3};
      8'hB6: d = '{M_ZPY, K_LDX, 3'd4};  8'hAE: d = '{M_ABS, K_LDX, 3'd4};
      8'hBE: d = '{M_ABSY, K_LDX, 3'd4};
      8'hA0: d = '{M_IMM, K_LDY, 3'd2};  8'hA4: d = '{M_ZP, K_LDY, 3'd3};
      8'hB4: d = '{M_ZPX, K_LDY, 3'd4};  8'hAC: d = '{M_ABS, K_LDY, 3'd4};
      8'hBC: d = '{M_ABSX, K_LDY, 3'd4};
      8'h85: d = '{M_ZP, K_STA, 3'd3};   8'h95: d = '{M_ZPX, K_STA, 3'd4};
      8'h8D: d = '{M_ABS, K_STA, 3'd4};  8'h9D: d = '{M_ABSX, K_STA, 3'd5};
      8'h99: d = '{M_ABSY, K_STA, 3'd5}; 8'h81: d = '{M_INDX, K_STA, 3'd6};
      8'h91: d = '{M_INDY, K_STA, 3'd6};
      8'h86: d = '{M_ZP, K_STX, 3'd3};   8'h96: d = '{M_ZPY, K_STX, 3'd4};
      8'h8E: d = '{M_ABS, K_STX, 3'd4};
      8'h84: d = '{M_ZP, K_STY, 3'd3};   8'h94: d = '{M_ZPX, K_STY, 3'd4};
      8'h8C: d = '{M_ABS, K_STY, 3'd4};
      8'h69: d = '{M_IMM, K_ADC, 3'd2};  8'h65: d = '{M_ZP, K_ADC, 3'd3};
      8'h75: d = '{M_ZPX, K_ADC, 3'd4};  8'h6D: d = '{M_ABS, K_ADC, 3'd4};
      8'h7D: d = '{M_ABSX, K_ADC, 3'd4}; 8'h79: d = '{M_ABSY, K_ADC, 3'd4};
      8'hE9: d = '{M_IMM, K_SBC, 3'd2};  8'hE5: d = '{M_ZP, K_SBC, 3'd3};
      8'hF5: d = '{M_ZPX, K_SBC, 3'd4};  8'hED: d = '{M_ABS, K_SBC, 3'd4};
      8'hFD: d = '{M_ABSX, K_SBC, 3'd4}; 8'hF9: d = '{M_ABSY, K_SBC, 3'd4};
      8'h29: d = '{M_IMM, K_AND, 3'd2};  8'h25: d = '{M_ZP, K_AND, 3'd3};
      8'h35: d = '{M_ZPX, K_AND, 3'd4};  8'h2D: d = '{M_ABS, K_AND, 3'd4};
      8'h3D: d = '{M_ABSX, K_AND, 3'd4}; 8'h39: d = '{M_ABSY, K_AND, 3'd4};
      8'h09: d = '{M_IMM, K_ORA, 3'd2};  8'h05: d = '{M_ZP, K_ORA, 3'd3};
      8'h15: d = '{M_ZPX, K_ORA, 3'd4};  8'h0D: d = '{M_ABS, K_ORA, 3'd4};
      8'h1D: d = '{M_ABSX, K_ORA, 3'd4}; 8'h19: d = '{M_ABSY, K_ORA, 3'd4};
      8'h49: d = '{M_IMM, K_EOR, 3'd2};  8'h45: d = '{M_ZP, K_EOR, 3'd3};
      8'h55: d = '{M_ZPX, K_EOR, 3'd4};  8'h4D: d = '{M_ABS, K_EOR, 3'd4};
      8'h5D: d = '{M_ABSX, K_EOR, 3'd4}; 8'h59: d = '{M_ABSY, K_EOR, 3'd4};
      8'hC9: d = '{M_IMM, K_CMP, 3'd2};  8'hC5: d = '{M_ZP, K_CMP, 3'd3};
      8'hD5: d = '{M_ZPX, K_CMP, 3'd4};  8'hCD: d = '{M_ABS, K_CMP, 3'd4};
      8'hDD: d = '{M_ABSX, K_CMP, 3'd4}; 8'hD9: d = '{M_ABSY, K_CMP, 3'd4};
      8'hE0: d = '{M_IMM, K_CPX, 3'd2};  8'hE4: d = '{M_ZP, K_CPX, 3'd3};
      8'hEC: d = '{M_ABS, K_CPX, 3'd4};
      8'hC0: d = '{M_IMM, K_CPY, 3'd2};  8'hC4: d = '{M_ZP, K_CPY, 3'd3};
      8'hCC: d = '{M_ABS, K_CPY, 3'd4};
      8'hE6: d = '{M_ZP, K_INC, 3'd5};   8'hF6: d = '{M_ZPX, K_INC, 3'd6};
      8'hEE: d = '{M_ABS, K_INC, 3'd6};  8'hFE: d = '{M_ABSX, K_INC, 3'd7};
      8'hC6: d = '{M_ZP, K_DEC, 3'd5};   8'hD6: d = '{M_ZPX, K_DEC, 3'd6};
      8'hCE: d = '{M_ABS, K_DEC, 3'd6};  8'hDE: d = '{M_ABSX, K_DEC, 3'd7};
      8'h24: d = '{M_ZP, K_BIT, 3'd3};   8'h2C: d = '{M_ABS, K_BIT, 3'd4};
      8'h90, 8'hB0, 8'hF0, 8'hD0, 8'h30, 8'h10, 8'h70, 8'h50:
        d = '{M_REL, K_NONE, 3'd2};
      8'h4C: d = '{M_JMP, K_NONE, 3'd3};  8'h6C: d = '{M_JMPI, K_NONE, 3'd5};
      8'h20: d = '{M_JSR, K_NONE, 3'd6};  8'h60: d = '{M_RTS, K_NONE, 3'd6};
      8'h40: d = '{M_RTI, K_NONE, 3'd6};  8'h00: d = '{M_BRK, K_NONE, 3'd7};
      8'h48: d = '{M_PHA, K_NONE, 3'd3};  8'h08: d = '{M_PHP, K_NONE, 3'd3};
      8'h68: d = '{M_PLA, K_NONE, 3'd4};  8'h28: d = '{M_PLP, K_NONE, 3'd4};
      default: d = '{M_IMP, K_NONE, 3'd2};
    endcase
    return d;
  endfunction

  function automatic logic [7:0] set_nz(input logic [7:0] p, input logic [7:0] v);
    logic [7:0] f;
    f = p & ~(F_NEG | F_ZERO);
    if (v[7]) f = f | F_NEG;
    if (v == 8'h00) f = f | F_ZERO;
    return f;
  endfunction

endpackage

/* src/cpu_core_6502_subset.sv */
// 6502-style core driven one bus access per request: every accepted input
// request (reset or read response) advances the sequencer by one step and
// yields exactly one bus access request. A request is taken every clock
// while the output register is empty or being drained, so the sustained
// rate is one access per cycle; the state update (decode, alu, address add)
// is the one combinational step between input and state/output registers.
// Result is visible the cycle after acceptance.
module cpu_core_6502_subset #(
  parameter int ADDRESS_BITS = 13
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       s_axis_tvalid_i,
  output logic                       s_axis_tready_o,
  input  logic [15:0]                s_axis_tdata_i,  // action, read_data
  output logic                       m_axis_tvalid_o,
  input  logic                       m_axis_tready_i,
  // bus_address, bus_write, write_data, instruction_start, instruction_cycles
  output logic [((ADDRESS_BITS+13+7)/8)*8-1:0] m_axis_tdata_o
);

  localparam int OutW = ((ADDRESS_BITS + 13 + 7) / 8) * 8;

  c6502s_pkg::core_t s_q, s_d;
  logic [ADDRESS_BITS-1:0] addr;
  logic wr, start;
  logic [7:0] wdata;
  logic [2:0] cyc;
  logic acc;
  logic vld_q;
  logic [OutW-1:0] out_q;

  assign s_axis_tready_o = !vld_q || m_axis_tready_i;
  assign acc = s_axis_tvalid_i && s_axis_tready_o;

  c6502s_exec u_exec (
    .s_i      (s_q),
    .action_i (s_axis_tdata_i[0]),
    .rdata_i  (s_axis_tdata_i[8:1]),
    .s_o      (s_d)
  );

  c6502s_bus #(.ADDRESS_BITS(ADDRESS_BITS)) u_bus (
    .s_i      (s_d),
    .addr_o   (addr),
    .wr_o     (wr),
    .wdata_o  (wdata),
    .start_o  (start),
    .cycles_o (cyc)
  );

  // core state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_q <= '{pc: 16'h0000, a: 8'h00, x: 8'h00, y: 8'h00, sp: 8'hFF,
               p: c6502s_pkg::F_IRQD, op: 8'h00, ph: c6502s_pkg::PH_RST_LO,
               al: 16'h0000, cyc: 32'd0, hold: 8'h00, last: 3'd0};
    end else if (acc) begin
      s_q <= s_d;
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (s_axis_tready_o) begin
      vld_q <= s_axis_tvalid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc) begin
      out_q <= OutW'({cyc, start, wdata, wr, addr});
    end
  end

  assign m_axis_tvalid_o = vld_q;
  assign m_axis_tdata_o = out_q;

endmodule

/* src/c6502s_exec.sv */
// one sequencer step: consumes the response and produces the next state
module c6502s_exec (
  input  c6502s_pkg::core_t s_i,
  input  logic              action_i,
  input  logic [7:0]        rdata_i,
  output c6502s_pkg::core_t s_o
);

  c6502s_pkg::op_info_t d;
  c6502s_pkg::op_info_t dn;
  logic [15:0] w;
  logic [8:0]  sum;
  logic [7:0]  opnd;
  logic [7:0]  rv;
  logic        bset;
  logic [15:0] bpc;
  logic [7:0]  bsel;

  always_comb begin
    c6502s_pkg::core_t n;
    logic        alu_en;
    logic [7:0]  v;
    logic        finish_en;
    logic [2:0]  fn;
    logic        access_en;
    n = s_i;
    v = rdata_i;
    d = c6502s_pkg::decode(s_i.op);
    dn = c6502s_pkg::decode(v);
    w = {v, s_i.hold};
    alu_en = 1'b0;
    finish_en = 1'b0;
    fn = d.ncyc;
    access_en = 1'b0;
    opnd = v;
    rv = 8'h00;
    sum = 9'h000;
    bset = 1'b0;
    bpc = 16'h0000;
    bsel = 8'h00;
    if (!action_i) begin
      n.sp = 8'hFF;
      n.p = c6502s_pkg::F_IRQD;
      n.ph = c6502s_pkg::PH_RST_LO;
    end else begin
      unique case (s_i.ph)
        c6502s_pkg::PH_RST_LO: begin
          n.hold = v;
          n.ph = c6502s_pkg::PH_RST_HI;
        end
        c6502s_pkg::PH_RST_HI: begin
          n.pc = w;
          n.last = 3'd0;
          n.ph = c6502s_pkg::PH_OPCODE;
        end
        c6502s_pkg::PH_OPCODE: begin
          n.op = v;
          n.pc = s_i.pc + 16'd1;
          fn = dn.ncyc;
          unique case (dn.mode)
            c6502s_pkg::M_IMP: begin
              finish_en = 1'b1;
              unique case (v)
                8'hAA: begin n.x = s_i.a; n.p = c6502s_pkg::set_nz(s_i.p, s_i.a); end
                8'hA8: begin n.y = s_i.a; n.p = c6502s_pkg::set_nz(s_i.p, s_i.a); end
                8'h8A: begin n.a = s_i.x; n.p = c6502s_pkg::set_nz(s_i.p, s_i.x); end
                8'h98: begin n.a = s_i.y; n.p = c6502s_pkg::set_nz(s_i.p, s_i.y); end
                8'h9A: n.sp = s_i.x;
                8'hBA: begin n.x = s_i.sp; n.p = c6502s_pkg::set_nz(s_i.p, s_i.sp); end
                8'hE8: begin
                  n.x = s_i.x + 8'd1; n.p = c6502s_pkg::set_nz(s_i.p, n.x);
                end
                8'hC8: begin
                  n.y = s_i.y + 8'd1; n.p = c6502s_pkg::set_nz(s_i.p, n.y);
                end
                8'hCA: begin
                  n.x = s_i.x - 8'd1; n.p = c6502s_pkg::set_nz(s_i.p, n.x);
                end
                8'h88: begin
                  n.y = s_i.y - 8'd1; n.p = c6502s_pkg::set_nz(s_i.p, n.y);
                end
                8'h0A: begin
                  n.a = {s_i.a[6:0], 1'b0};
                  n.p = c6502s_pkg::set_nz({s_i.p[7:1], s_i.a[7]}, n.a);
                end
                8'h2A: begin
                  n.a = {s_i.a[6:0], s_i.p[0]};
                  n.p = c6502s_pkg::set_nz({s_i.p[7:1], s_i.a[7]}, n.a);
                end
                8'h4A: begin
                  n.a = {1'b0, s_i.a[7:1]};
                  n.p = c6502s_pkg::set_nz({s_i.p[7:1], s_i.a[0]}, n.a);
                end
                8'h6A: begin
                  n.a = {s_i.p[0], s_i.a[7:1]};
                  n.p = c6502s_pkg::set_nz({s_i.p[7:1], s_i.a[0]}, n.a);
                end
                8'h18: n.p = s_i.p & ~c6502s_pkg::F_CARRY;
                8'h38: n.p = s_i.p | c6502s_pkg::F_CARRY;
                8'h58: n.p = s_i.p & ~c6502s_pkg::F_IRQD;
                8'h78: n.p = s_i.p | c6502s_pkg::F_IRQD;
                8'hB8: n.p = s_i.p & ~c6502s_pkg::F_OVFL;
                8'hD8: n.p = s_i.p & ~c6502s_pkg::F_DEC;
                8'hF8: n.p = s_i.p | c6502s_pkg::F_DEC;
                default: n.p = s_i.p;
              endcase
            end
            c6502s_pkg::M_PHA: begin n.hold = s_i.a; n.ph = c6502s_pkg::PH_PUSH3; end
            c6502s_pkg::M_PHP: begin
              n.hold = s_i.p | 8'h30; n.ph = c6502s_pkg::PH_PUSH3;
            end
            c6502s_pkg::M_BRK: begin n.hold = n.pc[15:8]; n.ph = c6502s_pkg::PH_PUSH1; end
            c6502s_pkg::M_PLA, c6502s_pkg::M_PLP, c6502s_pkg::M_RTI:
              n.ph = c6502s_pkg::PH_POP1;
            c6502s_pkg::M_RTS: n.ph = c6502s_pkg::PH_POP2;
            default: n.ph = c6502s_pkg::PH_OPER1;
          endcase
        end
        c6502s_pkg::PH_OPER1: begin
          n.pc = s_i.pc + 16'd1;
          unique case (d.mode)
            c6502s_pkg::M_IMM: begin alu_en = 1'b1; finish_en = 1'b1; end
            c6502s_pkg::M_REL: begin
              // condition flag picked by opcode bits 7:6, sense by bit 5
              unique case (s_i.op[7:6])
                2'd0: bsel = c6502s_pkg::F_NEG;
                2'd1: bsel = c6502s_pkg::F_OVFL;
                2'd2: bsel = c6502s_pkg::F_CARRY;
                default: bsel = c6502s_pkg::F_ZERO;
              endcase
              bset = (s_i.p & bsel) != 8'h00;
              bpc = n.pc + {{8{v[7]}}, v};
              finish_en = 1'b1;
              if (bset != s_i.op[5]) fn = 3'd2;
              else begin
                n.pc = bpc;
                fn = (bpc[15:8] != n.pc[15:8]) ? 3'd4 : 3'd3;
                fn = (bpc[15:8] != (s_i.pc[15:8] + {7'd0, &s_i.pc[7:0]})) ? 3'd4 : 3'd3;
              end
            end
            c6502s_pkg::M_ZP: begin n.al = {8'h00, v}; access_en = 1'b1; end
            c6502s_pkg::M_ZPX: begin n.al = {8'h00, v + s_i.x}; access_en = 1'b1; end
            c6502s_pkg::M_ZPY: begin n.al = {8'h00, v + s_i.y}; access_en = 1'b1; end
            c6502s_pkg::M_INDX: begin
              n.al = {8'h00, v + s_i.x}; n.ph = c6502s_pkg::PH_PTR_LO;
            end
            c6502s_pkg::M_INDY: begin n.al = {8'h00, v}; n.ph = c6502s_pkg::PH_PTR_LO; end
            default: begin n.hold = v; n.ph = c6502s_pkg::PH_OPER2; end
          endcase
        end
        c6502s_pkg::PH_OPER2: begin
          n.pc = s_i.pc + 16'd1;
          unique case (d.mode)
            c6502s_pkg::M_JMP: begin n.pc = w; finish_en = 1'b1; end
            c6502s_pkg::M_JMPI: begin n.al = w; n.ph = c6502s_pkg::PH_PTR_LO; end
            c6502s_pkg::M_JSR: begin
              n.al = w; n.hold = s_i.pc[15:8]; n.ph = c6502s_pkg::PH_PUSH1;
            end
            c6502s_pkg::M_ABSX: begin n.al = w + {8'h00, s_i.x}; access_en = 1'b1; end
            c6502s_pkg::M_ABSY: begin n.al = w + {8'h00, s_i.y}; access_en = 1'b1; end
            default: begin n.al = w; access_en = 1'b1; end
          endcase
        end
        c6502s_pkg::PH_PTR_LO: begin n.hold = v; n.ph = c6502s_pkg::PH_PTR_HI; end
        c6502s_pkg::PH_PTR_HI: begin
          if (d.mode == c6502s_pkg::M_INDX) begin
            n.al = w; access_en = 1'b1;
          end else if (d.mode == c6502s_pkg::M_INDY) begin
            n.al = w + {8'h00, s_i.y}; access_en = 1'b1;
          end else begin
            n.pc = w;
            if (d.mode == c6502s_pkg::M_BRK) n.p = s_i.p | c6502s_pkg::F_IRQD;
            finish_en = 1'b1;
          end
        end
        c6502s_pkg::PH_READ: begin
          if (d.kind == c6502s_pkg::K_INC || d.kind == c6502s_pkg::K_DEC) begin
            n.hold = (d.kind == c6502s_pkg::K_INC) ? v + 8'd1 : v - 8'd1;
            n.p = c6502s_pkg::set_nz(s_i.p, n.hold);
            n.ph = c6502s_pkg::PH_WRITE;
          end else begin
            alu_en = 1'b1; finish_en = 1'b1;
          end
        end
        c6502s_pkg::PH_WRITE: finish_en = 1'b1;
        c6502s_pkg::PH_PUSH1: begin
          n.sp = s_i.sp - 8'd1;
          n.hold = (d.mode == c6502s_pkg::M_JSR) ? s_i.pc[7:0] - 8'd1 : s_i.pc[7:0];
          n.ph = c6502s_pkg::PH_PUSH2;
        end
        c6502s_pkg::PH_PUSH2: begin
          n.sp = s_i.sp - 8'd1;
          if (d.mode == c6502s_pkg::M_BRK) begin
            n.hold = s_i.p | c6502s_pkg::F_BRKB; n.ph = c6502s_pkg::PH_PUSH3;
          end else begin
            n.pc = s_i.al; finish_en = 1'b1;
          end
        end
        c6502s_pkg::PH_PUSH3: begin
          n.sp = s_i.sp - 8'd1;
          if (d.mode == c6502s_pkg::M_BRK) begin
            n.al = c6502s_pkg::VEC_BRK; n.ph = c6502s_pkg::PH_PTR_LO;
          end else finish_en = 1'b1;
        end
        c6502s_pkg::PH_POP1: begin
          n.sp = s_i.sp + 8'd1;
          if (d.mode == c6502s_pkg::M_PLA) begin
            n.a = v; n.p = c6502s_pkg::set_nz(s_i.p, v); finish_en = 1'b1;
          end else if (d.mode == c6502s_pkg::M_PLP) begin
            n.p = v; finish_en = 1'b1;
          end else begin
            n.p = v; n.ph = c6502s_pkg::PH_POP2;
          end
        end
        c6502s_pkg::PH_POP2: begin
          n.sp = s_i.sp + 8'd1; n.hold = v; n.ph = c6502s_pkg::PH_POP3;
        end
        c6502s_pkg::PH_POP3: begin
          n.sp = s_i.sp + 8'd1;
          n.pc = (d.mode == c6502s_pkg::M_RTS) ? w + 16'd1 : w;
          finish_en = 1'b1;
        end
        default: begin finish_en = 1'b1; fn = 3'd0; end
      endcase

      // operand alu for loads, arithmetic, logic, compares and bit test
      if (alu_en) begin
        opnd = (d.kind == c6502s_pkg::K_SBC) ? ~v : v;
        unique case (d.kind)
          c6502s_pkg::K_LDA: begin n.a = v; n.p = c6502s_pkg::set_nz(s_i.p, v); end
          c6502s_pkg::K_LDX: begin n.x = v; n.p = c6502s_pkg::set_nz(s_i.p, v); end
          c6502s_pkg::K_LDY: begin n.y = v; n.p = c6502s_pkg::set_nz(s_i.p, v); end
          c6502s_pkg::K_ADC, c6502s_pkg::K_SBC: begin
            sum = {1'b0, s_i.a} + {1'b0, opnd} + {8'h00, s_i.p[0]};
            n.a = sum[7:0];
            n.p = c6502s_pkg::set_nz({s_i.p[7],
                   (~(s_i.a[7] ^ opnd[7])) & (s_i.a[7] ^ sum[7]),
                   s_i.p[5:1], sum[8]}, sum[7:0]);
          end
          c6502s_pkg::K_AND: begin
            n.a = s_i.a & v; n.p = c6502s_pkg::set_nz(s_i.p, n.a);
          end
          c6502s_pkg::K_ORA: begin
            n.a = s_i.a | v; n.p = c6502s_pkg::set_nz(s_i.p, n.a);
          end
          c6502s_pkg::K_EOR: begin
            n.a = s_i.a ^ v; n.p = c6502s_pkg::set_nz(s_i.p, n.a);
          end
          c6502s_pkg::K_CMP, c6502s_pkg::K_CPX, c6502s_pkg::K_CPY: begin
            rv = (d.kind == c6502s_pkg::K_CMP) ? s_i.a :
                 ((d.kind == c6502s_pkg::K_CPX) ? s_i.x : s_i.y);
            n.p = c6502s_pkg::set_nz({s_i.p[7:1], rv >= v}, rv - v);
          end
          c6502s_pkg::K_BIT:
            n.p = {v[7:6], s_i.p[5:2], (s_i.a & v) == 8'h00, s_i.p[0]};
          default: n.p = s_i.p;
        endcase
      end

      // memory access setup: stores latch their data
      if (access_en) begin
        if (d.kind == c6502s_pkg::K_STA || d.kind == c6502s_pkg::K_STX ||
            d.kind == c6502s_pkg::K_STY) begin
          n.hold = (d.kind == c6502s_pkg::K_STA) ? s_i.a :
                   ((d.kind == c6502s_pkg::K_STX) ? s_i.x : s_i.y);
          n.ph = c6502s_pkg::PH_WRITE;
        end else n.ph = c6502s_pkg::PH_READ;
      end

      // instruction completion
      if (finish_en) begin
        n.cyc = s_i.cyc + {29'd0, fn};
        n.last = fn;
        n.ph = c6502s_pkg::PH_OPCODE;
      end
    end
    s_o = n;
  end

endmodule

/* src/c6502s_bus.sv */
// forms the bus request from the sequencer state
module c6502s_bus #(
  parameter int ADDRESS_BITS = 13
) (
  input  c6502s_pkg::core_t        s_i,
  output logic [ADDRESS_BITS-1:0]  addr_o,
  output logic                     wr_o,
  output logic [7:0]               wdata_o,
  output logic                     start_o,
  output logic [2:0]               cycles_o
);

  logic [15:0] where;

  always_comb begin
    wr_o = 1'b0;
    wdata_o = 8'h00;
    unique case (s_i.ph)
      c6502s_pkg::PH_RST_LO: where = c6502s_pkg::VEC_RST_LO;
      c6502s_pkg::PH_RST_HI: where = c6502s_pkg::VEC_RST_HI;
      c6502s_pkg::PH_PTR_LO, c6502s_pkg::PH_READ: where = s_i.al;
      c6502s_pkg::PH_PTR_HI: where = {s_i.al[15:8], s_i.al[7:0] + 8'd1};
      c6502s_pkg::PH_WRITE: begin
        where = s_i.al; wr_o = 1'b1; wdata_o = s_i.hold;
      end
      c6502s_pkg::PH_PUSH1, c6502s_pkg::PH_PUSH2, c6502s_pkg::PH_PUSH3: begin
        where = {8'h01, s_i.sp}; wr_o = 1'b1; wdata_o = s_i.hold;
      end
      c6502s_pkg::PH_POP1, c6502s_pkg::PH_POP2, c6502s_pkg::PH_POP3:
        where = {8'h01, s_i.sp + 8'd1};
      default: where = s_i.pc;
    endcase
    addr_o = where[ADDRESS_BITS-1:0];
    start_o = s_i.ph == c6502s_pkg::PH_OPCODE;
    cycles_o = start_o ? s_i.last : 3'd0;
  end

endmodule

/* sim/cpu_core_6502_subset_test.sv */
`timescale 1ns / 1ps

module cpu_core_6502_subset_test;

  localparam int ABITS = 13;
  localparam int WATCHDOG_LIMIT = 5000;

  // fields from the highest bit down, as on m_axis_tdata_o
  typedef struct packed {
    logic [2:0]       cycles;
    logic             start;
    logic [7:0]       wdata;
    logic             wr;
    logic [ABITS-1:0] addr;
  } access_t;

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid_i;
  logic        s_axis_tready_o;
  logic [15:0] s_axis_tdata_i;
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i;
  logic [31:0] m_axis_tdata_o;

  cpu_core_6502_subset #(.ADDRESS_BITS(ABITS)) dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),   // action, read_data
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    // bus_address, bus_write, write_data, instruction_start, instruction_cycles
    .m_axis_tdata_o  (m_axis_tdata_o)
  );

  // shadow cpu state
  logic [15:0] cpu_pc, cpu_al;
  logic [7:0]  cpu_a, cpu_x, cpu_y, cpu_sp, cpu_p, cpu_op, cpu_hold;
  logic [3:0]  cpu_ph;
  logic [2:0]  cpu_last;
  logic [31:0] cpu_cycles;

  // bus the shadow cpu talks to, and the access it last issued
  logic [7:0]  memory [0:65535];
  logic [15:0] bus_addr16;
  logic        bus_wr;

  access_t pending_access[$];
  int      errors;
  int      idle_pct;
  int      stall_pct;
  int      quiet_cycles;

  // clock
  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  function automatic void flag_nz(input logic [7:0] v);
    cpu_p = (cpu_p & ~(c6502s_pkg::F_NEG | c6502s_pkg::F_ZERO))
            | (v[7] ? c6502s_pkg::F_NEG : 8'h00)
            | (v == 8'h00 ? c6502s_pkg::F_ZERO : 8'h00);
  endfunction

  function automatic void add_with_carry(input logic [7:0] v);
    logic [8:0] s;
    s = {1'b0, cpu_a} + {1'b0, v} + {8'h00, cpu_p[0]};
    cpu_p = cpu_p & ~(c6502s_pkg::F_CARRY | c6502s_pkg::F_OVFL);
    if (s[8]) cpu_p = cpu_p | c6502s_pkg::F_CARRY;
    if (!(cpu_a[7] ^ v[7]) && (cpu_a[7] ^ s[7])) cpu_p = cpu_p | c6502s_pkg::F_OVFL;
    cpu_a = s[7:0];
    flag_nz(cpu_a);
  endfunction

  function automatic void compare_reg(input logic [7:0] r, input logic [7:0] v);
    flag_nz(r - v);
    cpu_p = (cpu_p & ~c6502s_pkg::F_CARRY) | (r >= v ? c6502s_pkg::F_CARRY : 8'h00);
  endfunction

  function automatic void exec_kind(input c6502s_pkg::kind_e k, input logic [7:0] v);
    case (k)
      c6502s_pkg::K_LDA: begin cpu_a = v; flag_nz(v); end
      c6502s_pkg::K_LDX: begin cpu_x = v; flag_nz(v); end
      c6502s_pkg::K_LDY: begin cpu_y = v; flag_nz(v); end
      c6502s_pkg::K_ADC: add_with_carry(v);
      c6502s_pkg::K_SBC: add_with_carry(~v);
      c6502s_pkg::K_AND: begin cpu_a = cpu_a & v; flag_nz(cpu_a); end
      c6502s_pkg::K_ORA: begin cpu_a = cpu_a | v; flag_nz(cpu_a); end
      c6502s_pkg::K_EOR: begin cpu_a = cpu_a ^ v; flag_nz(cpu_a); end
      c6502s_pkg::K_CMP: compare_reg(cpu_a, v);
      c6502s_pkg::K_CPX: compare_reg(cpu_x, v);
      c6502s_pkg::K_CPY: compare_reg(cpu_y, v);
      c6502s_pkg::K_BIT:
        cpu_p = (cpu_p & ~(c6502s_pkg::F_NEG | c6502s_pkg::F_OVFL | c6502s_pkg::F_ZERO))
                | (v & 8'hC0) | ((cpu_a & v) != 8'h00 ? 8'h00 : c6502s_pkg::F_ZERO);
      default: ;
    endcase
  endfunction

  function automatic void exec_implied(input logic [7:0] c);
    logic cin;
    cin = cpu_p[0];
    case (c)
      8'hAA: begin cpu_x = cpu_a; flag_nz(cpu_x); end
      8'hA8: begin cpu_y = cpu_a; flag_nz(cpu_y); end
      8'h8A: begin cpu_a = cpu_x; flag_nz(cpu_a); end
      8'h98: begin cpu_a = cpu_y; flag_nz(cpu_a); end
      8'h9A: cpu_sp = cpu_x;
      8'hBA: begin cpu_x = cpu_sp; flag_nz(cpu_x); end
      8'hE8: begin cpu_x = cpu_x + 8'd1; flag_nz(cpu_x); end
      8'hC8: begin cpu_y = cpu_y + 8'd1; flag_nz(cpu_y); end
      8'hCA: begin cpu_x = cpu_x - 8'd1; flag_nz(cpu_x); end
      8'h88: begin cpu_y = cpu_y - 8'd1; flag_nz(cpu_y); end
      8'h0A, 8'h2A: begin
        cpu_p[0] = cpu_a[7];
        cpu_a = {cpu_a[6:0], c == 8'h2A ? cin : 1'b0};
        flag_nz(cpu_a);
      end
      8'h4A, 8'h6A: begin
        cpu_p[0] = cpu_a[0];
        cpu_a = {c == 8'h6A ? cin : 1'b0, cpu_a[7:1]};
        flag_nz(cpu_a);
      end
      8'h18: cpu_p = cpu_p & ~c6502s_pkg::F_CARRY;
      8'h38: cpu_p = cpu_p | c6502s_pkg::F_CARRY;
      8'h58: cpu_p = cpu_p & ~c6502s_pkg::F_IRQD;
      8'h78: cpu_p = cpu_p | c6502s_pkg::F_IRQD;
      8'hB8: cpu_p = cpu_p & ~c6502s_pkg::F_OVFL;
      8'hD8: cpu_p = cpu_p & ~c6502s_pkg::F_DEC;
      8'hF8: cpu_p = cpu_p | c6502s_pkg::F_DEC;
      default: ;
    endcase
  endfunction

  function automatic void retire(input logic [2:0] n);
    cpu_cycles = cpu_cycles + n;
    cpu_last = n;
    cpu_ph = c6502s_pkg::PH_OPCODE;
  endfunction

  function automatic void enter_data_access(input c6502s_pkg::op_info_t d);
    if (d.kind == c6502s_pkg::K_STA || d.kind == c6502s_pkg::K_STX ||
        d.kind == c6502s_pkg::K_STY) begin
      cpu_hold = d.kind == c6502s_pkg::K_STA ? cpu_a :
                 (d.kind == c6502s_pkg::K_STX ? cpu_x : cpu_y);
      cpu_ph = c6502s_pkg::PH_WRITE;
    end else begin
      cpu_ph = c6502s_pkg::PH_READ;
    end
  endfunction

  function automatic void take_branch(input logic [7:0] disp);
    logic [7:0]  sel;
    logic [15:0] prev;
    case (cpu_op[7:6])
      2'd0: sel = c6502s_pkg::F_NEG;
      2'd1: sel = c6502s_pkg::F_OVFL;
      2'd2: sel = c6502s_pkg::F_CARRY;
      default: sel = c6502s_pkg::F_ZERO;
    endcase
    prev = cpu_pc;
    if (((cpu_p & sel) != 8'h00) != cpu_op[5]) begin
      retire(3'd2);
    end else begin
      cpu_pc = cpu_pc + {{8{disp[7]}}, disp};
      retire(((cpu_pc ^ prev) & 16'hFF00) != 16'h0000 ? 3'd4 : 3'd3);
    end
  endfunction

  // one sequencer step on a bus response byte
  function automatic void step_on_byte(input logic [7:0] v);
    c6502s_pkg::op_info_t d;
    logic [15:0]          w;
    d = c6502s_pkg::decode(cpu_op);
    w = {v, cpu_hold};
    case (cpu_ph)
      c6502s_pkg::PH_RST_LO: begin cpu_hold = v; cpu_ph = c6502s_pkg::PH_RST_HI; end
      c6502s_pkg::PH_RST_HI: begin
        cpu_pc = w; cpu_last = 3'd0; cpu_ph = c6502s_pkg::PH_OPCODE;
      end
      c6502s_pkg::PH_OPCODE: begin
        cpu_op = v;
        cpu_pc = cpu_pc + 16'd1;
        d = c6502s_pkg::decode(v);
        case (d.mode)
          c6502s_pkg::M_IMP: begin exec_implied(v); retire(d.ncyc); end
          c6502s_pkg::M_PHA: begin cpu_hold = cpu_a; cpu_ph = c6502s_pkg::PH_PUSH3; end
          c6502s_pkg::M_PHP: begin
            cpu_hold = cpu_p | 8'h30; cpu_ph = c6502s_pkg::PH_PUSH3;
          end
          c6502s_pkg::M_BRK: begin
            cpu_hold = cpu_pc[15:8]; cpu_ph = c6502s_pkg::PH_PUSH1;
          end
          c6502s_pkg::M_PLA, c6502s_pkg::M_PLP, c6502s_pkg::M_RTI:
            cpu_ph = c6502s_pkg::PH_POP1;
          c6502s_pkg::M_RTS: cpu_ph = c6502s_pkg::PH_POP2;
          default: cpu_ph = c6502s_pkg::PH_OPER1;
        endcase
      end
      c6502s_pkg::PH_OPER1: begin
        cpu_pc = cpu_pc + 16'd1;
        case (d.mode)
          c6502s_pkg::M_IMM: begin exec_kind(d.kind, v); retire(d.ncyc); end
          c6502s_pkg::M_REL: take_branch(v);
          c6502s_pkg::M_ZP: begin cpu_al = {8'h00, v}; enter_data_access(d); end
          c6502s_pkg::M_ZPX: begin cpu_al = {8'h00, v + cpu_x}; enter_data_access(d); end
          c6502s_pkg::M_ZPY: begin cpu_al = {8'h00, v + cpu_y}; enter_data_access(d); end
          c6502s_pkg::M_INDX: begin
            cpu_al = {8'h00, v + cpu_x}; cpu_ph = c6502s_pkg::PH_PTR_LO;
          end
          c6502s_pkg::M_INDY: begin cpu_al = {8'h00, v}; cpu_ph = c6502s_pkg::PH_PTR_LO; end
          default: begin cpu_hold = v; cpu_ph = c6502s_pkg::PH_OPER2; end
        endcase
      end
      c6502s_pkg::PH_OPER2: begin
        cpu_pc = cpu_pc + 16'd1;
        case (d.mode)
          c6502s_pkg::M_JMP: begin cpu_pc = w; retire(d.ncyc); end
          c6502s_pkg::M_JMPI: begin cpu_al = w; cpu_ph = c6502s_pkg::PH_PTR_LO; end
          c6502s_pkg::M_JSR: begin
            cpu_al = w;
            cpu_hold = 8'((cpu_pc - 16'd1) >> 8);
            cpu_ph = c6502s_pkg::PH_PUSH1;
          end
          c6502s_pkg::M_ABSX: begin cpu_al = w + {8'h00, cpu_x}; enter_data_access(d); end
          c6502s_pkg::M_ABSY: begin cpu_al = w + {8'h00, cpu_y}; enter_data_access(d); end
          default: begin cpu_al = w; enter_data_access(d); end
        endcase
      end
      c6502s_pkg::PH_PTR_LO: begin cpu_hold = v; cpu_ph = c6502s_pkg::PH_PTR_HI; end
      c6502s_pkg::PH_PTR_HI: begin
        if (d.mode == c6502s_pkg::M_INDX) begin
          cpu_al = w;
          enter_data_access(d);
        end else if (d.mode == c6502s_pkg::M_INDY) begin
          cpu_al = w + {8'h00, cpu_y};
          enter_data_access(d);
        end else begin
          cpu_pc = w;
          if (d.mode == c6502s_pkg::M_BRK) cpu_p = cpu_p | c6502s_pkg::F_IRQD;
          retire(d.ncyc);
        end
      end
      c6502s_pkg::PH_READ: begin
        if (d.kind == c6502s_pkg::K_INC || d.kind == c6502s_pkg::K_DEC) begin
          cpu_hold = d.kind == c6502s_pkg::K_INC ? v + 8'd1 : v - 8'd1;
          flag_nz(cpu_hold);
          cpu_ph = c6502s_pkg::PH_WRITE;
        end else begin
          exec_kind(d.kind, v);
          retire(d.ncyc);
        end
      end
      c6502s_pkg::PH_WRITE: retire(d.ncyc);
      c6502s_pkg::PH_PUSH1: begin
        cpu_sp = cpu_sp - 8'd1;
        cpu_hold = d.mode == c6502s_pkg::M_JSR ? 8'(cpu_pc - 16'd1) : cpu_pc[7:0];
        cpu_ph = c6502s_pkg::PH_PUSH2;
      end
      c6502s_pkg::PH_PUSH2: begin
        cpu_sp = cpu_sp - 8'd1;
        if (d.mode == c6502s_pkg::M_BRK) begin
          cpu_hold = cpu_p | c6502s_pkg::F_BRKB;
          cpu_ph = c6502s_pkg::PH_PUSH3;
        end else begin
          cpu_pc = cpu_al;
          retire(d.ncyc);
        end
      end
      c6502s_pkg::PH_PUSH3: begin
        cpu_sp = cpu_sp - 8'd1;
        if (d.mode == c6502s_pkg::M_BRK) begin
          cpu_al = c6502s_pkg::VEC_BRK;
          cpu_ph = c6502s_pkg::PH_PTR_LO;
        end else begin
          retire(d.ncyc);
        end
      end
      c6502s_pkg::PH_POP1: begin
        cpu_sp = cpu_sp + 8'd1;
        if (d.mode == c6502s_pkg::M_PLA) begin
          cpu_a = v;
          flag_nz(v);
          retire(d.ncyc);
        end else if (d.mode == c6502s_pkg::M_PLP) begin
          cpu_p = v;
          retire(d.ncyc);
        end else begin
          cpu_p = v;
          cpu_ph = c6502s_pkg::PH_POP2;
        end
      end
      c6502s_pkg::PH_POP2: begin
        cpu_sp = cpu_sp + 8'd1; cpu_hold = v; cpu_ph = c6502s_pkg::PH_POP3;
      end
      c6502s_pkg::PH_POP3: begin
        cpu_sp = cpu_sp + 8'd1;
        cpu_pc = d.mode == c6502s_pkg::M_RTS ? w + 16'd1 : w;
        retire(d.ncyc);
      end
      default: retire(3'd0);
    endcase
  endfunction

  // advance the shadow cpu by one request and queue the bus access it issues
  function automatic void predict_access(input logic act, input logic [7:0] rdata);
    access_t e;
    if (!act) begin
      cpu_sp = 8'hFF;
      cpu_p = c6502s_pkg::F_IRQD;
      cpu_ph = c6502s_pkg::PH_RST_LO;
    end else begin
      step_on_byte(rdata);
    end
    bus_wr = 1'b0;
    e.wdata = 8'h00;
    case (cpu_ph)
      c6502s_pkg::PH_RST_LO: bus_addr16 = c6502s_pkg::VEC_RST_LO;
      c6502s_pkg::PH_RST_HI: bus_addr16 = c6502s_pkg::VEC_RST_HI;
      c6502s_pkg::PH_PTR_LO, c6502s_pkg::PH_READ: bus_addr16 = cpu_al;
      c6502s_pkg::PH_PTR_HI: bus_addr16 = {cpu_al[15:8], cpu_al[7:0] + 8'd1};
      c6502s_pkg::PH_WRITE: begin
        bus_addr16 = cpu_al; bus_wr = 1'b1; e.wdata = cpu_hold;
      end
      c6502s_pkg::PH_PUSH1, c6502s_pkg::PH_PUSH2, c6502s_pkg::PH_PUSH3: begin
        bus_addr16 = {8'h01, cpu_sp};
        bus_wr = 1'b1;
        e.wdata = cpu_hold;
      end
      c6502s_pkg::PH_POP1, c6502s_pkg::PH_POP2, c6502s_pkg::PH_POP3:
        bus_addr16 = {8'h01, cpu_sp + 8'd1};
      default: bus_addr16 = cpu_pc;
    endcase
    if (bus_wr) memory[bus_addr16] = e.wdata;
    e.addr = bus_addr16[ABITS-1:0];
    e.wr = bus_wr;
    e.start = cpu_ph == c6502s_pkg::PH_OPCODE;
    e.cycles = cpu_ph == c6502s_pkg::PH_OPCODE ? cpu_last : 3'd0;
    pending_access.push_back(e);
  endfunction

  // send one request, idling first as the current phase asks
  task automatic send_request(input logic act, input logic [7:0] rdata);
    bit gap;
    gap = 1'b0;
    while ($urandom_range(99) < idle_pct) begin
      if (!gap) s_axis_tvalid_i <= 1'b0;
      gap = 1'b1;
      @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i <= {7'd0, rdata, act};
    do @(posedge clk_i); while (!s_axis_tready_o);
    predict_access(act, rdata);
  endtask

  // answer the last issued access from the bus image
  task automatic respond(input int noise_pct);
    logic [7:0] b;
    b = memory[bus_addr16];
    if ($urandom_range(99) < noise_pct) b = 8'($urandom);
    send_request(1'b1, b);
  endtask

  // receiver stalls
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready_i <= 1'b0;
    end else begin
      m_axis_tready_i <= $urandom_range(99) >= stall_pct;
    end
  end

  // result checker
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      if (pending_access.size() == 0) begin
        $display("%0t: unexpected access, actual %h", $realtime, m_axis_tdata_o);
        errors++;
      end else begin
        if (m_axis_tdata_o[ABITS+12:0] != pending_access[0] ||
            m_axis_tdata_o[31:ABITS+13] != 0) begin
          $display("%0t: access mismatch, expected addr %h wr %b wd %h start %b cyc %0d",
                   $realtime, pending_access[0].addr, pending_access[0].wr,
                   pending_access[0].wdata, pending_access[0].start, pending_access[0].cycles);
          $display("%0t:                   actual addr %h wr %b wd %h start %b cyc %0d",
                   $realtime, m_axis_tdata_o[ABITS-1:0], m_axis_tdata_o[ABITS],
                   m_axis_tdata_o[ABITS+8:ABITS+1], m_axis_tdata_o[ABITS+9],
                   m_axis_tdata_o[ABITS+12:ABITS+10]);
          errors++;
        end
        void'(pending_access.pop_front());
      end
    end
  end

  // watchdog on handshake progress
  always @(posedge clk_i) begin
    if ((s_axis_tvalid_i && s_axis_tready_o) || (m_axis_tvalid_o && m_axis_tready_i))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // short hand-written program covering wraps, stack, brk, jsr/rts, rti
  task automatic test_directed_program();
    int i;
    logic [7:0] prog_main [0:6];
    logic [7:0] prog_far [0:10];
    logic [7:0] prog_sub [0:9];
    prog_main = '{8'hA9, 8'h80, 8'h69, 8'h80, 8'h6C, 8'hFF, 8'h02};
    prog_far = '{8'hA2, 8'h01, 8'hB5, 8'hFF, 8'h9A, 8'h48, 8'h08, 8'h00, 8'h00, 8'h00, 8'h00};
    prog_sub = '{8'h20, 8'h00, 8'h04, 8'h02, 8'h08, 8'h28, 8'hF8, 8'hF0, 8'h80, 8'h40};
    for (i = 0; i < 65536; i++) memory[16'(i)] = 8'h00;
    memory[16'hFFFC] = 8'h00; memory[16'hFFFD] = 8'h02;
    memory[16'hFFFE] = 8'h20; memory[16'hFFFF] = 8'h03;
    for (i = 0; i < 7; i++) memory[16'h0200 + 16'(i)] = prog_main[i];
    // jump pointer straddles a page end, high byte comes from 0x0200
    memory[16'h02FF] = 8'h10;
    for (i = 0; i < 11; i++) memory[16'hA910 + 16'(i)] = prog_far[i];
    for (i = 0; i < 10; i++) memory[16'h0320 + 16'(i)] = prog_sub[i];
    memory[16'h0400] = 8'h60;
    memory[16'h0000] = 8'hFF;
    bus_addr16 = c6502s_pkg::VEC_RST_LO;
    for (i = 0; i < 60; i++) respond(0);
    // reset in the middle of an instruction
    send_request(1'b0, 8'hFF);
    for (i = 0; i < 4; i++) respond(0);
  endtask

  // random programs, mostly documented opcodes, with noise and resets
  task automatic test_random_program(input int n_items, input int idle, input int stall);
    int i, k;
    logic [7:0] b;
    idle_pct = idle;
    stall_pct = stall;
    for (i = 0; i < 65536; i++) begin
      b = 8'($urandom);
      for (k = 0; k < 2 && c6502s_pkg::decode(b).mode == c6502s_pkg::M_IMP; k++)
        b = 8'($urandom);
      memory[16'(i)] = b;
    end
    send_request(1'b0, 8'($urandom));
    for (i = 0; i < n_items; i++) begin
      if ($urandom_range(99) == 0) send_request(1'b0, 8'($urandom));
      else respond(8);
    end
  endtask

  initial begin
    errors = 0;
    idle_pct = 0;
    stall_pct = 0;
    quiet_cycles = 0;
    rst_ni = 1'b0;
    s_axis_tvalid_i = 1'b0;
    s_axis_tdata_i = '0;
    cpu_pc = '0; cpu_a = '0; cpu_x = '0; cpu_y = '0; cpu_sp = 8'hFF;
    cpu_p = c6502s_pkg::F_IRQD;
    cpu_op = '0; cpu_ph = c6502s_pkg::PH_RST_LO; cpu_al = '0; cpu_cycles = '0;
    cpu_hold = '0;
    cpu_last = '0; bus_addr16 = c6502s_pkg::VEC_RST_LO; bus_wr = 1'b0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed_program();
    test_random_program(220, 0, 0);
    test_random_program(220, 61, 0);
    test_random_program(220, 0, 61);
    test_random_program(220, 21, 21);

    s_axis_tvalid_i <= 1'b0;
    while (pending_access.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

/* cpu_core_6502_subset.f */
src/c6502s_pkg.sv
src/c6502s_exec.sv
src/c6502s_bus.sv
src/cpu_core_6502_subset.sv
sim/cpu_core_6502_subset_test.sv
